// ===== hdl/aabb_frustum_cull_defines.svh =====
// Assertion macros shared by the box frustum culling RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// Checked at every clock edge outside reset.
`define AFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define AFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/afc_pkg.sv =====
// Package for the box frustum culling block: field widths, register map and
// arithmetic widths. It depends on nothing else.
`timescale 1ns / 1ps

package afc_pkg;

  localparam int PLANE_COUNT  = 6;
  localparam int AXES         = 3;

  localparam int NORM_W       = 12;
  localparam int COORD_W      = 28;
  localparam int HALF_W       = 27;
  localparam int DIST_W       = 28;
  localparam int MARGIN_W     = 16;
  localparam int PLANE_W      = 64;
  localparam int DATA_W       = 64;

  // Distance is Q20.8, products are Q.18, so distance is scaled by 2^10.
  localparam int DIST_SHIFT   = 10;

  localparam int PROD_W       = NORM_W + COORD_W;
  localparam int SPREAD_W     = NORM_W + HALF_W;
  localparam int ACC_W        = PROD_W + 4;

  // Register map: planes first, then the margin register.
  localparam int IDX_W        = $clog2(PLANE_COUNT + 1);
  localparam int PIDX_W       = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int ADDR_W       = IDX_W + 3;
  localparam logic [IDX_W-1:0] REG_MARGIN = IDX_W'(PLANE_COUNT);

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd2621;

  // Bit positions inside a packed plane register.
  localparam int NX_LSB       = 52;
  localparam int NY_LSB       = 40;
  localparam int NZ_LSB       = 28;

endpackage

// ===== hdl/afc_box_if.sv =====
// Stream interface carrying one box transaction: centre and half extents.
// Depends on afc_pkg for the field widths.
`timescale 1ns / 1ps

interface afc_box_if;
  logic                                valid;
  logic                                ready;
  logic signed [afc_pkg::COORD_W-1:0]  center_x;
  logic signed [afc_pkg::COORD_W-1:0]  center_y;
  logic signed [afc_pkg::COORD_W-1:0]  center_z;
  logic        [afc_pkg::HALF_W-1:0]   half_x;
  logic        [afc_pkg::HALF_W-1:0]   half_y;
  logic        [afc_pkg::HALF_W-1:0]   half_z;

  modport source (
    output valid, center_x, center_y, center_z, half_x, half_y, half_z,
    input  ready
  );

  modport sink (
    input  valid, center_x, center_y, center_z, half_x, half_y, half_z,
    output ready
  );
endinterface

// ===== hdl/afc_result_if.sv =====
// Stream interface carrying one culling result transaction.
// Stands alone; the payload is two single-bit flags.
`timescale 1ns / 1ps

interface afc_result_if;
  logic valid;
  logic ready;
  logic visible;
  logic fully_inside;

  modport source (
    output valid, visible, fully_inside,
    input  ready
  );

  modport sink (
    input  valid, visible, fully_inside,
    output ready
  );
endinterface

// ===== hdl/aabb_frustum_cull.sv =====
// Top level of the box frustum culling block: plane registers, APB port and
// the four-stage test pipeline. Depends on afc_pkg, afc_box_if, afc_result_if
// and the assertion macros in aabb_frustum_cull_defines.svh.
`timescale 1ns / 1ps

`include "aabb_frustum_cull_defines.svh"

// The block tests one axis-aligned box per transaction against six planes held
// in APB registers and returns one result transaction per box: visible is low
// when the box lies wholly outside some plane, and fully_inside is high only
// when the box lies inside all of them. It accepts one box in every clock
// cycle while the result side takes results. The box passes through four
// register stages (multiply, sum, compare and reduce); the first loads at the
// accepting edge and the last is the result register. Each stage holds its
// contents while the stage after it is full and held, so a stalled result
// side fills the pipeline before the box side is held off. Planes live at
// byte addresses 0 to 40 in steps of 8 and the margin at 48, in 64-bit slots
// with a 16-bit margin; a write takes effect at the access cycle and the
// registers should only be changed while no box is in flight. After reset all
// planes are zero and every box is reported culled.
module aabb_frustum_cull (
  input  logic                        clk,
  input  logic                        rst,
  afc_box_if.sink                     box,
  afc_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afc_pkg::ADDR_W-1:0]  paddr,
  input  logic [afc_pkg::DATA_W-1:0]  pwdata,
  output logic [afc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------

  logic [afc_pkg::PLANE_W-1:0]  plane [afc_pkg::PLANE_COUNT];
  logic [afc_pkg::MARGIN_W-1:0] margin;

  logic [afc_pkg::IDX_W-1:0]    reg_idx;
  logic                         wr_en;

  // Registers sit on 8-byte boundaries, so the index is the address above the
  // low three bits. Indices past the margin register are ignored on write and
  // read back as zero.
  assign reg_idx = paddr[afc_pkg::ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
        plane[p] <= '0;
      end
      margin <= afc_pkg::MARGIN_RESET;
    end else if (wr_en) begin
      if (reg_idx < afc_pkg::REG_MARGIN) begin
        plane[reg_idx[afc_pkg::PIDX_W-1:0]] <= pwdata;
      end else if (reg_idx == afc_pkg::REG_MARGIN) begin
        margin <= pwdata[afc_pkg::MARGIN_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < afc_pkg::REG_MARGIN) begin
      prdata = plane[reg_idx[afc_pkg::PIDX_W-1:0]];
    end else if (reg_idx == afc_pkg::REG_MARGIN) begin
      prdata = afc_pkg::DATA_W'(margin);
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------------

  // A stage may load when it is empty or when its contents move on in the same
  // cycle. The chain runs from the result side back to the box side.
  logic mul_valid, sum_valid, cmp_valid;
  logic out_free, cmp_free, sum_free, mul_free;

  assign out_free  = !result.valid || result.ready;
  assign cmp_free  = !cmp_valid || out_free;
  assign sum_free  = !sum_valid || cmp_free;
  assign mul_free  = !mul_valid || sum_free;
  assign box.ready = mul_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid    <= 1'b0;
      sum_valid    <= 1'b0;
      cmp_valid    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (mul_free) begin
        mul_valid <= box.valid;
      end
      if (sum_free) begin
        sum_valid <= mul_valid;
      end
      if (cmp_free) begin
        cmp_valid <= sum_valid;
      end
      if (out_free) begin
        result.valid <= cmp_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: per plane, normal times centre and |normal| times half extent
  // ---------------------------------------------------------------------------

  logic signed [afc_pkg::NORM_W-1:0]   norm     [afc_pkg::PLANE_COUNT][afc_pkg::AXES];
  logic        [afc_pkg::NORM_W-1:0]   norm_abs [afc_pkg::PLANE_COUNT][afc_pkg::AXES];
  logic signed [afc_pkg::COORD_W-1:0]  center   [afc_pkg::AXES];
  logic        [afc_pkg::HALF_W-1:0]   half     [afc_pkg::AXES];

  logic signed [afc_pkg::PROD_W-1:0]   dot_prod    [afc_pkg::PLANE_COUNT][afc_pkg::AXES];
  logic        [afc_pkg::SPREAD_W-1:0] spread_prod [afc_pkg::PLANE_COUNT][afc_pkg::AXES];

  assign center[0] = box.center_x;
  assign center[1] = box.center_y;
  assign center[2] = box.center_z;
  assign half[0]   = box.half_x;
  assign half[1]   = box.half_y;
  assign half[2]   = box.half_z;

  // The magnitude of the most negative normal component still fits in the
  // unsigned field width, so no extra bit is needed.
  always_comb begin
    for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
      norm[p][0] = plane[p][afc_pkg::NX_LSB +: afc_pkg::NORM_W];
      norm[p][1] = plane[p][afc_pkg::NY_LSB +: afc_pkg::NORM_W];
      norm[p][2] = plane[p][afc_pkg::NZ_LSB +: afc_pkg::NORM_W];
      for (int a = 0; a < afc_pkg::AXES; a++) begin
        norm_abs[p][a] = norm[p][a][afc_pkg::NORM_W-1] ? (~norm[p][a] + 1'b1) : norm[p][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_free) begin
      for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
        for (int a = 0; a < afc_pkg::AXES; a++) begin
          dot_prod[p][a]    <= afc_pkg::PROD_W'(norm[p][a]) * afc_pkg::PROD_W'(center[a]);
          spread_prod[p][a] <= afc_pkg::SPREAD_W'(norm_abs[p][a])
                               * afc_pkg::SPREAD_W'(half[a]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: centre dot product less distance, and the box spread
  // ---------------------------------------------------------------------------

  logic signed [afc_pkg::DIST_W-1:0] plane_dist    [afc_pkg::PLANE_COUNT];
  logic signed [afc_pkg::ACC_W-1:0]  dot_less_dist [afc_pkg::PLANE_COUNT];
  logic        [afc_pkg::ACC_W-1:0]  spread        [afc_pkg::PLANE_COUNT];

  always_comb begin
    for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
      plane_dist[p] = plane[p][afc_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_free) begin
      for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
        dot_less_dist[p] <= afc_pkg::ACC_W'(dot_prod[p][0])
                          + afc_pkg::ACC_W'(dot_prod[p][1])
                          + afc_pkg::ACC_W'(dot_prod[p][2])
                          - (afc_pkg::ACC_W'(plane_dist[p]) <<< afc_pkg::DIST_SHIFT);
        spread[p]        <= afc_pkg::ACC_W'(spread_prod[p][0])
                          + afc_pkg::ACC_W'(spread_prod[p][1])
                          + afc_pkg::ACC_W'(spread_prod[p][2]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: near and far corner tests against the margin
  // ---------------------------------------------------------------------------

  // A corner is outside when its signed distance is at least minus the margin,
  // that is when distance plus margin is not negative.
  logic signed [afc_pkg::ACC_W-1:0] near_val [afc_pkg::PLANE_COUNT];
  logic signed [afc_pkg::ACC_W-1:0] far_val  [afc_pkg::PLANE_COUNT];
  logic        [afc_pkg::PLANE_COUNT-1:0] near_out;
  logic        [afc_pkg::PLANE_COUNT-1:0] far_out;

  always_comb begin
    for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
      near_val[p] = dot_less_dist[p] - $signed(spread[p]) + $signed(afc_pkg::ACC_W'(margin));
      far_val[p]  = dot_less_dist[p] + $signed(spread[p]) + $signed(afc_pkg::ACC_W'(margin));
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_free) begin
      for (int p = 0; p < afc_pkg::PLANE_COUNT; p++) begin
        near_out[p] <= !near_val[p][afc_pkg::ACC_W-1];
        far_out[p]  <= !far_val[p][afc_pkg::ACC_W-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: combine the planes into the result register
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk) begin
    if (out_free) begin
      result.visible      <= !(|near_out);
      result.fully_inside <= !(|far_out);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  `AFC_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !result.valid, "result valid after reset")
  `AFC_ASSERT(a_inside_implies_visible, result.valid |-> (result.visible || !result.fully_inside), "box fully inside but culled")
  `AFC_ASSERT(a_hold_only_when_full, !box.ready |-> (result.valid && !result.ready), "box side held off with room in the pipeline")
  `AFC_ASSERT(a_accept_loads_stage, (box.valid && box.ready) |=> mul_valid, "accepted box did not enter the multiply stage")

endmodule
